// File: rtl/mcu_pkg.sv
// Shared types and constants of the measurement calibration unit.
package mcu_pkg;

    // Pipeline depth: stages inside the datapath units, plus the output register.
    localparam int PIPE_STAGES = 10;
    localparam int NUM_STAGES  = PIPE_STAGES + 1;

    // Quantity codes carried by a request.
    localparam logic [2:0] OP_VPP  = 3'd0;
    localparam logic [2:0] OP_VRMS = 3'd1;
    localparam logic [2:0] OP_FREQ = 3'd2;
    localparam logic [2:0] OP_COMP = 3'd3;
    localparam logic [2:0] OP_DC   = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_ENABLED   = 3'd0;
    localparam logic [2:0] REG_VPP_GAIN  = 3'd1;
    localparam logic [2:0] REG_VRMS_GAIN = 3'd2;
    localparam logic [2:0] REG_COMP_GAIN = 3'd3;
    localparam logic [2:0] REG_FREQ_LOW  = 3'd4;
    localparam logic [2:0] REG_FREQ_HIGH = 3'd5;
    localparam logic [2:0] REG_DC_LOW    = 3'd6;
    localparam logic [2:0] REG_DC_HIGH   = 3'd7;

    // Which unit supplies the result of a request.
    typedef enum logic [1:0] {
        SEL_PASS,
        SEL_POLY,
        SEL_DIV
    } mcu_sel_t;

    // Operands of the polynomial unit.
    typedef struct packed {
        logic signed [31:0] c0;
        logic signed [31:0] lin;
        logic signed [31:0] sq;
        logic signed [31:0] cube;
        logic signed [32:0] x;
        logic [31:0]        ax;
        logic               xneg;
        logic               is_dc;
    } poly_in_t;

endpackage

// File: rtl/mcu_div.sv
// Pipelined restoring divider for the voltage gain path.
module mcu_div (
    input  logic                             clk,
    input  logic [mcu_pkg::PIPE_STAGES-1:0]  load,
    input  logic [31:0]                      ux,
    input  logic [15:0]                      gain,
    output logic [31:0]                      quo,
    output logic                             sat
);
    import mcu_pkg::*;

    typedef struct packed {
        logic [16:0] rem;
        logic [31:0] dvd;
        logic [31:0] quo;
        logic [16:0] den;
        logic        sat;
    } div_stage_t;

    // Four quotient bits per stage.
    function automatic div_stage_t div_step4(input div_stage_t a);
        div_stage_t r;
        logic [17:0] t;
        r = a;
        for (int i = 0; i < 4; i++)
        begin
            t = {r.rem, r.dvd[31]};
            r.dvd = {r.dvd[30:0], 1'b0};
            if (t >= {1'b0, r.den})
            begin
                r.rem = 17'(t - {1'b0, r.den});
                r.quo = {r.quo[30:0], 1'b1};
            end
            else
            begin
                r.rem = t[16:0];
                r.quo = {r.quo[30:0], 1'b0};
            end
        end
        return r;
    endfunction

    div_stage_t st_reg  [PIPE_STAGES];
    div_stage_t st_next [PIPE_STAGES];
    logic [45:0] num;

    // Numerator X*8192 + g over divisor 2g gives the rounded quotient.
    always_comb
    begin
        num = {1'b0, ux, 13'd0} + 46'(gain);
        st_next[0].rem = 17'(num[45:32]);
        st_next[0].dvd = num[31:0];
        st_next[0].quo = 32'd0;
        st_next[0].den = {gain, 1'b0};
        st_next[0].sat = 17'(num[45:32]) >= {gain, 1'b0};
        for (int s = 0; s < 8; s++)
        begin
            st_next[s + 1] = div_step4(st_reg[s]);
        end
        st_next[PIPE_STAGES - 1] = st_reg[PIPE_STAGES - 2];
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < PIPE_STAGES; s++)
        begin
            if (load[s])
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign quo = st_reg[PIPE_STAGES - 1].quo;
    assign sat = st_reg[PIPE_STAGES - 1].sat;

endmodule

// File: rtl/mcu_poly.sv
// Pipelined cubic Horner polynomial with rounding and saturation.
module mcu_poly (
    input  logic                             clk,
    input  logic [mcu_pkg::PIPE_STAGES-1:0]  load,
    input  mcu_pkg::poly_in_t                op_in,
    output logic [32:0]                      result
);
    import mcu_pkg::*;

    localparam logic signed [57:0] DC_MIN   = -58'sd2147483648;
    localparam logic signed [57:0] DC_MAX   = 58'sd2147483647;
    localparam logic signed [57:0] FREQ_MIN = 58'sd0;
    localparam logic signed [57:0] FREQ_MAX = 58'sd4294967295;

    // Operands travel alongside the arithmetic.
    poly_in_t side_reg [PIPE_STAGES];

    logic signed [64:0]  pk_reg, pk_next;
    logic signed [65:0]  acc1_reg, acc1_next;
    logic signed [65:0]  pl_reg, pl_next;
    logic signed [66:0]  ph_reg, ph_next;
    logic signed [99:0]  acc2_reg, acc2_next;
    logic [96:0]         mag2_reg, mag2_next;
    logic                neg2_reg;
    logic [63:0]         q0_reg, q0_next;
    logic [63:0]         q1_reg, q1_next;
    logic [64:0]         q2_reg, q2_next;
    logic                sneg6_reg;
    logic [127:0]        mag3_reg, mag3_next;
    logic                ovf7_reg, ovf_next;
    logic                sneg7_reg;
    logic [127:0]        acc3_reg, acc3_next;
    logic                ovf8_reg;
    logic                sneg8_reg;
    logic signed [56:0]  n_reg, n_next;
    logic                gt_reg, gt_next;
    logic                eq_reg, eq_next;
    logic                ovf9_reg;
    logic                sneg9_reg;

    logic [99:0]         abs2;
    logic signed [55:0]  qv;
    logic signed [57:0]  nr;
    logic signed [57:0]  lo_b;
    logic signed [57:0]  hi_b;
    logic                inc;

    // Horner steps: k*x + s, then times x plus l, then times x.
    always_comb
    begin
        pk_next   = $signed(side_reg[0].cube) * side_reg[0].x;
        acc1_next = 66'(pk_reg) + (66'($signed(side_reg[1].sq)) <<< 24);
        pl_next   = $signed({1'b0, acc1_reg[31:0]}) * side_reg[2].x;
        ph_next   = $signed(acc1_reg[65:32]) * side_reg[2].x;
        acc2_next = 100'(pl_reg) + (100'(ph_reg) <<< 32)
                    + (100'($signed(side_reg[3].lin)) <<< 42);
        abs2      = acc2_reg[99] ? 100'(-acc2_reg) : acc2_reg;
        mag2_next = abs2[96:0];
    end

    // Last product in magnitude form; the top partial product flags overflow.
    always_comb
    begin
        q0_next   = 64'(mag2_reg[31:0]) * 64'(side_reg[5].ax);
        q1_next   = 64'(mag2_reg[63:32]) * 64'(side_reg[5].ax);
        q2_next   = 65'(mag2_reg[96:64]) * 65'(side_reg[5].ax);
        ovf_next  = q2_reg > (65'd1 << 61);
        mag3_next = {q2_reg[63:0], 64'd0} + {32'd0, q1_reg, 32'd0} + {64'd0, q0_reg};
        acc3_next = sneg7_reg ? (~mag3_reg + 128'd1) : mag3_reg;
    end

    // Scale by 2^-72, add the offset and find the rounding direction.
    always_comb
    begin
        qv      = acc3_reg[127:72];
        n_next  = 57'($signed(side_reg[8].c0)) + 57'(qv);
        gt_next = acc3_reg[71] && (|acc3_reg[70:0]);
        eq_next = acc3_reg[71] && !(|acc3_reg[70:0]);
    end

    // Round half away from zero, then clamp to the field's range.
    always_comb
    begin
        inc  = gt_reg || (eq_reg && !n_reg[56]);
        nr   = 58'(n_reg) + $signed({57'd0, inc});
        lo_b = side_reg[9].is_dc ? DC_MIN : FREQ_MIN;
        hi_b = side_reg[9].is_dc ? DC_MAX : FREQ_MAX;
        if (ovf9_reg)
        begin
            result = sneg9_reg ? lo_b[32:0] : hi_b[32:0];
        end
        else if (nr < lo_b)
        begin
            result = lo_b[32:0];
        end
        else if (nr > hi_b)
        begin
            result = hi_b[32:0];
        end
        else
        begin
            result = nr[32:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            side_reg[0] <= op_in;
        end
        for (int s = 1; s < PIPE_STAGES; s++)
        begin
            if (load[s])
            begin
                side_reg[s] <= side_reg[s - 1];
            end
        end
        if (load[1])
        begin
            pk_reg <= pk_next;
        end
        if (load[2])
        begin
            acc1_reg <= acc1_next;
        end
        if (load[3])
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
        if (load[4])
        begin
            acc2_reg <= acc2_next;
        end
        if (load[5])
        begin
            mag2_reg <= mag2_next;
            neg2_reg <= acc2_reg[99];
        end
        if (load[6])
        begin
            q0_reg    <= q0_next;
            q1_reg    <= q1_next;
            q2_reg    <= q2_next;
            sneg6_reg <= neg2_reg ^ side_reg[5].xneg;
        end
        if (load[7])
        begin
            mag3_reg  <= mag3_next;
            ovf7_reg  <= ovf_next;
            sneg7_reg <= sneg6_reg;
        end
        if (load[8])
        begin
            acc3_reg  <= acc3_next;
            ovf8_reg  <= ovf7_reg;
            sneg8_reg <= sneg7_reg;
        end
        if (load[9])
        begin
            n_reg     <= n_next;
            gt_reg    <= gt_next;
            eq_reg    <= eq_next;
            ovf9_reg  <= ovf8_reg;
            sneg9_reg <= sneg8_reg;
        end
    end

endmodule

// File: rtl/measurement_calibration_unit_core.sv
// Top level of the measurement calibration unit: configuration, pipeline control, result mux.
//
// The unit takes one request per clock while in_ready is high and returns results in the
// order it accepted them. Every request flows through the same 11-stage pipeline: a
// divider that resolves four quotient bits per stage for the voltage gains, and a
// Horner polynomial whose second and third wide products are split into partial products
// on their own stages. A stage holds its request when the one after it is full and stalled,
// so input stops only when all 11 stages hold results the consumer has not taken.
module measurement_calibration_unit_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic signed [32:0] reading,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [32:0] calibrated,
    output logic        applied
);
    import mcu_pkg::*;

    typedef struct packed {
        mcu_sel_t    sel;
        logic [32:0] pass_val;
    } meta_t;

    logic        enabled_reg;
    logic [15:0] vpp_gain_reg;
    logic [15:0] vrms_gain_reg;
    logic [15:0] comp_gain_reg;
    logic [63:0] freq_low_reg;
    logic [63:0] freq_high_reg;
    logic [63:0] dc_low_reg;
    logic [63:0] dc_high_reg;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] rdy;
    meta_t       meta_reg [PIPE_STAGES];
    meta_t       meta_next;
    logic [32:0] calibrated_reg, calibrated_next;
    logic        applied_reg, applied_next;

    poly_in_t    poly_op;
    logic [31:0] ux;
    logic [15:0] gain;
    logic [32:0] poly_res;
    logic [31:0] div_quo;
    logic        div_sat;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b1;
            vpp_gain_reg  <= 16'd8192;
            vrms_gain_reg <= 16'd8192;
            comp_gain_reg <= 16'd8192;
            freq_low_reg  <= 64'h4000_0000_0000_0000;
            freq_high_reg <= 64'd0;
            dc_low_reg    <= 64'h4000_0000_0000_0000;
            dc_high_reg   <= 64'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLED:   enabled_reg   <= cfg_data[0];
                REG_VPP_GAIN:  vpp_gain_reg  <= cfg_data[15:0];
                REG_VRMS_GAIN: vrms_gain_reg <= cfg_data[15:0];
                REG_COMP_GAIN: comp_gain_reg <= cfg_data[15:0];
                REG_FREQ_LOW:  freq_low_reg  <= cfg_data;
                REG_FREQ_HIGH: freq_high_reg <= cfg_data;
                REG_DC_LOW:    dc_low_reg    <= cfg_data;
                REG_DC_HIGH:   dc_high_reg   <= cfg_data;
                default:       enabled_reg   <= enabled_reg;
            endcase
        end
    end

    // Request decode: operands for both units and the path taken.
    always_comb
    begin
        ux = reading[31:0];
        case (opcode)
            OP_VPP:  gain = vpp_gain_reg;
            OP_VRMS: gain = vrms_gain_reg;
            default: gain = comp_gain_reg;
        endcase

        poly_op.is_dc = (opcode == OP_DC);
        poly_op.x     = poly_op.is_dc ? $signed({ux[31], ux}) : $signed({1'b0, ux});
        poly_op.xneg  = poly_op.is_dc && ux[31];
        poly_op.ax    = poly_op.xneg ? (~ux + 32'd1) : ux;
        poly_op.c0    = poly_op.is_dc ? dc_low_reg[31:0]   : freq_low_reg[31:0];
        poly_op.lin   = poly_op.is_dc ? dc_low_reg[63:32]  : freq_low_reg[63:32];
        poly_op.sq    = poly_op.is_dc ? dc_high_reg[31:0]  : freq_high_reg[31:0];
        poly_op.cube  = poly_op.is_dc ? dc_high_reg[63:32] : freq_high_reg[63:32];

        meta_next.sel      = SEL_PASS;
        meta_next.pass_val = reading;
        case (opcode)
            OP_VPP, OP_VRMS, OP_COMP:
            begin
                meta_next.pass_val = {1'b0, ux};
                if (enabled_reg && gain != 16'd0)
                begin
                    meta_next.sel = SEL_DIV;
                end
            end
            OP_FREQ:
            begin
                meta_next.pass_val = {1'b0, ux};
                if (enabled_reg)
                begin
                    meta_next.sel = SEL_POLY;
                end
            end
            OP_DC:
            begin
                meta_next.pass_val = {ux[31], ux};
                if (enabled_reg)
                begin
                    meta_next.sel = SEL_POLY;
                end
            end
            default:
            begin
                meta_next.pass_val = reading;
            end
        endcase
    end

    // A stage may load when it is empty or the stage after it moves on.
    always_comb
    begin
        rdy[NUM_STAGES - 1] = !valid_reg[NUM_STAGES - 1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i + 1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    valid_reg[i] <= valid_reg[i - 1];
                end
            end
        end
    end

    // Path selection travels with the request.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            meta_reg[0] <= meta_next;
        end
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            if (rdy[i])
            begin
                meta_reg[i] <= meta_reg[i - 1];
            end
        end
        if (rdy[NUM_STAGES - 1])
        begin
            calibrated_reg <= calibrated_next;
            applied_reg    <= applied_next;
        end
    end

    mcu_poly u_poly (
        .clk    (clk),
        .load   (rdy[PIPE_STAGES-1:0]),
        .op_in  (poly_op),
        .result (poly_res)
    );

    mcu_div u_div (
        .clk  (clk),
        .load (rdy[PIPE_STAGES-1:0]),
        .ux   (ux),
        .gain (gain),
        .quo  (div_quo),
        .sat  (div_sat)
    );

    // Result mux into the output register.
    always_comb
    begin
        case (meta_reg[PIPE_STAGES - 1].sel)
            SEL_POLY:
            begin
                calibrated_next = poly_res;
                applied_next    = 1'b1;
            end
            SEL_DIV:
            begin
                calibrated_next = div_sat ? 33'h0_FFFF_FFFF : {1'b0, div_quo};
                applied_next    = 1'b1;
            end
            default:
            begin
                calibrated_next = meta_reg[PIPE_STAGES - 1].pass_val;
                applied_next    = 1'b0;
            end
        endcase
    end

    assign out_valid  = valid_reg[NUM_STAGES - 1];
    assign calibrated = calibrated_reg;
    assign applied    = applied_reg;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the measurement calibration unit core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;

    // One row of the directed table; cal and app are only used when chk is set.
    typedef struct {
        logic [2:0]  op;
        logic [32:0] rd;
        bit          chk;
        logic [32:0] cal;
        bit          app;
    } row_t;

    typedef struct {
        logic [32:0] cal;
        logic        app;
    } calib_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic signed [32:0] reading;
    logic        out_valid;
    logic        out_ready;
    logic signed [32:0] calibrated;
    logic        applied;

    logic [63:0] cfg_shadow [8];
    calib_t      pending_results [$];
    bit          literal_valid;
    calib_t      literal_result;
    int          mismatches;
    int          checked;
    int          cycles;
    int          requests_sent;
    bit          long_hold_req;

    measurement_calibration_unit_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .reading(reading),
        .out_valid(out_valid), .out_ready(out_ready),
        .calibrated(calibrated), .applied(applied)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sign extension helpers for the coefficient fields.
    function automatic longint sext32(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [127:0] widen(input longint v);
        return {{64{v[63]}}, v};
    endfunction

    // Sign-magnitude product of a 128-bit value and a 32-bit magnitude, with the
    // overflow guard that saturates once the magnitude could reach 2^125.
    function automatic logic [127:0] wide_mul(input logic [127:0] a, input longint b,
                                              ref bit ovf);
        bit           neg;
        logic [127:0] ua;
        logic [63:0]  ub;
        logic [63:0]  ahi;
        logic [127:0] r;
        neg = 1'b0;
        ua = a;
        if (a[127])
        begin
            ua = -a;
            neg = 1'b1;
        end
        if (b < 0)
        begin
            ub = -b;
            neg = !neg;
        end
        else
        begin
            ub = b;
        end
        ub = {32'b0, ub[31:0]};
        ahi = ua[127:64];
        if (ahi != 0 && ub > ((64'h1 << 61) / ahi))
        begin
            ovf = 1'b1;
            return '0;
        end
        r = ua * {64'b0, ub};
        return neg ? -r : r;
    endfunction

    // Cubic Horner evaluation: C0 + L*X/2^30 + S*X^2/2^48 + K*X^3/2^72, rounded and clamped.
    function automatic longint cubic_correct(input logic [63:0] clo, input logic [63:0] chi,
                                             input longint x, input longint lob,
                                             input longint hib);
        longint       c0, lin, sq, cube, q, n;
        bit           ovf, pos;
        logic [127:0] acc;
        logic [7:0]   rhi;
        c0   = sext32(clo[31:0]);
        lin  = sext32(clo[63:32]);
        sq   = sext32(chi[31:0]);
        cube = sext32(chi[63:32]);
        ovf  = 1'b0;
        acc = wide_mul(widen(cube), x, ovf) + widen(sq * 16777216);
        acc = wide_mul(acc, x, ovf) + (widen(lin) << 42);
        pos = !acc[127];
        if (x < 0)
            pos = !pos;
        acc = wide_mul(acc, x, ovf);
        if (ovf)
            return pos ? hib : lob;
        q = longint'($signed(acc) >>> 72);
        n = c0 + q;
        rhi = acc[71:64];
        if (rhi > 8'h80 || (rhi == 8'h80 && (acc[63:0] != 0 || n >= 0)))
            n = n + 1;
        if (n < lob)
            n = lob;
        if (n > hib)
            n = hib;
        return n;
    endfunction

    // Expected result of one request under the current register settings.
    function automatic calib_t calibrate(input logic [2:0] op, input logic [32:0] raw);
        calib_t      r;
        logic [63:0] ux;
        logic [63:0] g;
        logic [63:0] q;
        longint      v;
        ux = {32'b0, raw[31:0]};
        r.cal = raw;
        r.app = 1'b0;
        if (op == OP_VPP || op == OP_VRMS || op == OP_FREQ || op == OP_COMP)
        begin
            r.cal = ux[32:0];
            if (cfg_shadow[REG_ENABLED][0])
            begin
                if (op == OP_FREQ)
                begin
                    v = cubic_correct(cfg_shadow[REG_FREQ_LOW], cfg_shadow[REG_FREQ_HIGH],
                                      longint'(ux), 0, 64'hFFFFFFFF);
                    r.cal = v[32:0];
                    r.app = 1'b1;
                end
                else
                begin
                    g = (op == OP_VPP)  ? cfg_shadow[REG_VPP_GAIN][15:0] :
                        (op == OP_VRMS) ? cfg_shadow[REG_VRMS_GAIN][15:0] :
                                          cfg_shadow[REG_COMP_GAIN][15:0];
                    if (g != 0)
                    begin
                        q = (ux * 8192 + g) / (2 * g);
                        if (q > 64'hFFFFFFFF)
                            q = 64'hFFFFFFFF;
                        r.cal = q[32:0];
                        r.app = 1'b1;
                    end
                end
            end
        end
        else if (op == OP_DC)
        begin
            v = sext32(raw[31:0]);
            r.cal = v[32:0];
            if (cfg_shadow[REG_ENABLED][0])
            begin
                v = cubic_correct(cfg_shadow[REG_DC_LOW], cfg_shadow[REG_DC_HIGH], v,
                                  -64'sd2147483648, 64'sd2147483647);
                r.cal = v[32:0];
                r.app = 1'b1;
            end
        end
        return r;
    endfunction

    // Record the expectation of each accepted request and check each accepted result.
    always @(posedge clk)
    begin
        calib_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pending_results.push_back(literal_valid ? literal_result
                                                        : calibrate(opcode, reading));
                requests_sent++;
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("ERROR: unexpected result calibrated=%h applied=%b",
                                 calibrated, applied);
                end
                else
                begin
                    want = pending_results.pop_front();
                    checked++;
                    if (calibrated !== want.cal || applied !== want.app)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("ERROR: result %0d expected %h/%b got %h/%b",
                                     checked, want.cal, want.app, calibrated, applied);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
            $display("measurement_calibration_unit_core test failed");
            $finish;
        end
    end

    // Result side: alternates between always ready, random stalls and heavy stalls,
    // and holds off for a long stretch on request so that the pipeline fills.
    initial
    begin
        int seg_left;
        int mode;
        out_ready = 1'b0;
        seg_left = 0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (120) @(negedge clk);
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 150);
                mode = $urandom_range(0, 2);
            end
            seg_left--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Present one request and hold it until it is taken.
    task automatic send_request(input logic [2:0] op, input logic [32:0] rd);
        in_valid <= 1'b1;
        opcode   <= op;
        reading  <= rd;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Sender gaps: bursts of random length separated by random idle stretches.
    int burst_left;
    task automatic sender_pause();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 30);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // The write enable stays high across back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_shadow[idx] = val;
        @(negedge clk);
    endtask

    // Let every outstanding request drain before touching the registers.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (NUM_STAGES + 4) @(negedge clk);
    endtask

    function automatic logic [63:0] random_coef(input int style);
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case (style)
            // Near-unity linear term with a small offset.
            0: v = {32'h4000_0000 + 32'($urandom_range(0, 65535)) - 32'd32768,
                    32'($urandom_range(0, 2000)) - 32'd1000};
            1: v = {32'($urandom_range(0, 65535)) - 32'd32768, $urandom() >> 12};
            default: ;
        endcase
        return v;
    endfunction

    // Random reading with emphasis on the ends of the range.
    function automatic logic [32:0] random_reading();
        case ($urandom_range(0, 5))
            0: return 33'($urandom_range(0, 100));
            1: return {1'($urandom()), 32'hFFFF_FFFF - 32'($urandom_range(0, 100))};
            2: return {1'($urandom()), 32'h8000_0000 + 32'($urandom_range(0, 100)) - 32'd50};
            3: return 33'($urandom_range(0, 10000000));
            default: return {1'($urandom()), $urandom()};
        endcase
    endfunction

    row_t directed [] = '{
        '{OP_VPP,  33'd0,          1, 33'd0,          1},
        '{OP_VPP,  33'd1000,       1, 33'd500,        1},
        '{OP_VRMS, 33'd3,          0, 33'd0,          0},
        '{OP_COMP, 33'h0FFFFFFFF,  1, 33'h080000000,  1},
        '{OP_VRMS, 33'h1FFFFFFFF,  1, 33'h080000000,  1},
        '{OP_FREQ, 33'd0,          1, 33'd0,          1},
        '{OP_FREQ, 33'h0FFFFFFFF,  1, 33'h0FFFFFFFF,  1},
        '{OP_FREQ, 33'h112345678,  1, 33'h012345678,  1},
        '{OP_DC,   33'h080000000,  1, 33'h180000000,  1},
        '{OP_DC,   33'h07FFFFFFF,  1, 33'h07FFFFFFF,  1},
        '{OP_DC,   33'h1FFFFFFFF,  1, 33'h1FFFFFFFF,  1},
        '{OP_DC,   33'd12345,      0, 33'd0,          0},
        '{3'd5,    33'h1DEADBEEF,  1, 33'h1DEADBEEF,  0},
        '{3'd6,    33'd0,          1, 33'd0,          0},
        '{3'd7,    33'h0FFFFFFFF,  1, 33'h0FFFFFFFF,  0}
    };

    // Register settings per phase: extremes first, then random ones.
    task automatic program_phase(input int phase);
        case (phase)
            0: ;
            1:
            begin
                write_reg(REG_ENABLED, 64'd0);
            end
            2:
            begin
                write_reg(REG_ENABLED, 64'd1);
                write_reg(REG_VPP_GAIN, 64'd0);
                write_reg(REG_VRMS_GAIN, 64'd1);
                write_reg(REG_COMP_GAIN, 64'hFFFF);
                write_reg(REG_FREQ_LOW, 64'h7FFF_FFFF_7FFF_FFFF);
                write_reg(REG_FREQ_HIGH, 64'h7FFF_FFFF_7FFF_FFFF);
                write_reg(REG_DC_LOW, 64'h8000_0000_8000_0000);
                write_reg(REG_DC_HIGH, 64'h8000_0000_8000_0000);
            end
            3:
            begin
                write_reg(REG_VPP_GAIN, 64'hFFFF);
                write_reg(REG_VRMS_GAIN, 64'd0);
                write_reg(REG_COMP_GAIN, 64'd1);
                write_reg(REG_FREQ_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
                write_reg(REG_FREQ_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
                write_reg(REG_DC_LOW, 64'h0);
                write_reg(REG_DC_HIGH, 64'h0000_0001_0000_0000);
            end
            default:
            begin
                write_reg(REG_ENABLED, {$urandom(), $urandom()} | (phase != 7));
                write_reg(REG_VPP_GAIN, {48'b0, 16'($urandom_range(1, 65535))});
                write_reg(REG_VRMS_GAIN, {$urandom(), $urandom()});
                write_reg(REG_COMP_GAIN, 64'($urandom_range(0, 65535)));
                write_reg(REG_FREQ_LOW, random_coef(phase % 3));
                write_reg(REG_FREQ_HIGH, random_coef((phase + 1) % 3));
                write_reg(REG_DC_LOW, random_coef((phase + 2) % 3));
                write_reg(REG_DC_HIGH, random_coef(phase % 3));
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    // Main sequence: reset, directed table, then phases of random requests.
    initial
    begin
        cfg_shadow = '{64'd1, 64'd8192, 64'd8192, 64'd8192,
                       64'h4000_0000_0000_0000, 64'd0, 64'h4000_0000_0000_0000, 64'd0};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ENABLED;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_VPP;
        reading = '0;
        literal_valid = 1'b0;
        literal_result = '{default: '0};
        mismatches = 0;
        checked = 0;
        cycles = 0;
        requests_sent = 0;
        long_hold_req = 1'b0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            literal_valid = directed[i].chk;
            literal_result = '{directed[i].cal, directed[i].app};
            send_request(directed[i].op, directed[i].rd);
            literal_valid = 1'b0;
            sender_pause();
        end

        for (int phase = 0; phase < 11; phase++)
        begin
            wait_drained();
            program_phase(phase);
            if (phase == 4)
                long_hold_req = 1'b1;
            repeat (95)
            begin
                send_request(3'($urandom_range(0, 8) < 8 ? $urandom_range(0, 4)
                                                         : $urandom_range(5, 7)),
                             random_reading());
                sender_pause();
            end
        end

        wait_drained();
        $display("Checked %0d of %0d requests over 11 register settings, with gains and",
                 checked, requests_sent);
        $display("coefficients at their extremes, calibration off, and a stalled output.");
        if (mismatches == 0)
            $display("measurement_calibration_unit_core test passed");
        else
            $display("measurement_calibration_unit_core test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/mcu_pkg.sv
rtl/mcu_div.sv
rtl/mcu_poly.sv
rtl/measurement_calibration_unit_core.sv
tb/sv/tb.sv
